// File: hdl/sparse_matrix_entry_store_macros.svh
// Assertion macros for the sparse matrix entry store.
`ifndef SPARSE_MATRIX_ENTRY_STORE_MACROS_SVH
`define SPARSE_MATRIX_ENTRY_STORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low
`define SMES_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smes assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low
`define SMES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smes assertion failed");
`else
`define SMES_ASSERT_NOW(lbl, ante, cons)
`define SMES_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/smes_pkg.sv
// Package for the sparse matrix entry store: command codes, states and cell link types.
package smes_pkg;

	// request commands
	typedef enum logic [1:0] {
		CMD_GET  = 2'd0,
		CMD_SET  = 2'd1,
		CMD_ACC  = 2'd2,
		CMD_RSVD = 2'd3
	} cmd_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_COMMIT
	} state_t;

	// flags of the scan token passed from cell to cell
	typedef struct packed {
		logic live;
		logic hit;
		logic free_found;
	} tok_flags_t;

	// write-back command broadcast to every cell
	typedef struct packed {
		logic del_hit;
		logic upd_hit;
		logic ins_free;
	} cell_ctl_t;

endpackage

// File: hdl/smes_cell.sv
// One slot of the entry store chain: holds a triple, matches the token and passes it on.
module smes_cell
	import smes_pkg::*;
#(
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [INDEX_BITS-1:0] req_row,
	input  logic [INDEX_BITS-1:0] req_col,
	input  logic [VALUE_BITS-1:0] new_value,
	input  cell_ctl_t             ctl,
	input  tok_flags_t            tok_in_f,
	input  logic [VALUE_BITS-1:0] tok_in_v,
	output tok_flags_t            tok_out_f,
	output logic [VALUE_BITS-1:0] tok_out_v
);

	logic                  valid_q;
	logic [INDEX_BITS-1:0] row_q;
	logic [INDEX_BITS-1:0] col_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  hit_q;
	logic                  free_q;
	tok_flags_t            tok_f_q;
	logic [VALUE_BITS-1:0] tok_v_q;
	logic                  match;
	logic                  claim;

	// compare the stored coordinate; claim the slot if it is the first free one
	assign match = valid_q && (row_q == req_row) && (col_q == req_col);
	assign claim = !valid_q && !tok_in_f.free_found;

	// mark this slot as the token goes past
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			tok_f_q <= '0;
		end else begin
			tok_f_q.live       <= tok_in_f.live;
			tok_f_q.hit        <= tok_in_f.hit | (tok_in_f.live & match);
			tok_f_q.free_found <= tok_in_f.free_found | (tok_in_f.live & !valid_q);
			if (tok_in_f.live) begin
				hit_q  <= match;
				free_q <= claim;
			end
		end
	end

	// carry the hit value along with the token
	always_ff @(posedge clk) begin
		tok_v_q <= match ? value_q : tok_in_v;
	end

	// slot valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit_q && ctl.del_hit) begin
			valid_q <= 1'b0;
		end else if (free_q && ctl.ins_free) begin
			valid_q <= 1'b1;
		end
	end

	// slot payload: update on a hit, fill on an insert
	always_ff @(posedge clk) begin
		if (hit_q && ctl.upd_hit) begin
			value_q <= new_value;
		end else if (free_q && ctl.ins_free) begin
			row_q   <= req_row;
			col_q   <= req_col;
			value_q <= new_value;
		end
	end

	assign tok_out_f = tok_f_q;
	assign tok_out_v = tok_v_q;

endmodule

// File: hdl/sparse_matrix_entry_store.sv
// Top level of the sparse matrix entry store: request control and the chain of slot cells.
//
// Each request (get, set or accumulate on one row/column cell) is taken when start is high and
// busy is low, and gives exactly one result, shown for a single cycle with done high; the
// receiver cannot hold it off. The next request is taken only after the last one is through:
// a scan token walks the chain of slot cells one slot a cycle to find the matching slot and
// the lowest free one, then ST_CALC forms the saturated sum and ST_COMMIT writes back to the
// cells; done is registered from ST_COMMIT. Slot flags clear at reset with no clearing pass.
`include "sparse_matrix_entry_store_macros.svh"

module sparse_matrix_entry_store
	import smes_pkg::*;
#(
	parameter int ENTRIES    = 64,
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic [INDEX_BITS-1:0] row_index,
	input  logic [INDEX_BITS-1:0] col_index,
	input  logic [VALUE_BITS-1:0] cell_value,
	output logic                  done,
	output logic [VALUE_BITS-1:0] result_value,
	output logic                  was_present,
	output logic [6:0]            nonzero_count,
	output logic                  table_full_drop,
	output logic                  saturated
);

	localparam int CW = $clog2(ENTRIES + 1);

	state_t                state_q;
	state_t                state_d;
	logic                  accept;

	cmd_t                  cmd_q;
	logic [INDEX_BITS-1:0] row_q;
	logic [INDEX_BITS-1:0] col_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  launch_q;

	logic                  end_hit_q;
	logic                  end_free_q;
	logic [VALUE_BITS-1:0] end_val_q;
	logic [VALUE_BITS-1:0] newv_q;
	logic                  clamp_q;
	logic [CW-1:0]         count_q;

	logic                  done_q;
	logic [VALUE_BITS-1:0] result_q;
	logic                  present_q;
	logic                  drop_q;
	logic                  sat_q;

	tok_flags_t            tok_f [ENTRIES+1];
	logic [VALUE_BITS-1:0] tok_v [ENTRIES+1];
	cell_ctl_t             ctl;

	logic [VALUE_BITS-1:0] old_val;
	logic [VALUE_BITS:0]   sum_ext;
	logic                  sum_ovf;
	logic [VALUE_BITS-1:0] sat_val;
	logic                  is_write;
	logic                  newv_zero;
	logic                  do_drop;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SCAN;
			ST_SCAN:   if (tok_f[ENTRIES].live) state_d = ST_CALC;
			ST_CALC:   state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// hold the request for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			row_q <= row_index;
			col_q <= col_index;
			val_q <= cell_value;
		end
	end

	// launch the scan token into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= 1'b0;
		end else begin
			launch_q <= accept;
		end
	end

	assign tok_f[0] = '{live: launch_q, hit: 1'b0, free_found: 1'b0};
	assign tok_v[0] = '0;

	// chain of slot cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		smes_cell #(
			.INDEX_BITS(INDEX_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.req_row   (row_q),
			.req_col   (col_q),
			.new_value (newv_q),
			.ctl       (ctl),
			.tok_in_f  (tok_f[i]),
			.tok_in_v  (tok_v[i]),
			.tok_out_f (tok_f[i+1]),
			.tok_out_v (tok_v[i+1])
		);
	end

	// saturating add of the stored value and the request value
	assign old_val = end_hit_q ? end_val_q : '0;
	assign sum_ext = {old_val[VALUE_BITS-1], old_val} + {val_q[VALUE_BITS-1], val_q};
	assign sum_ovf = sum_ext[VALUE_BITS] != sum_ext[VALUE_BITS-1];
	assign sat_val = sum_ext[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
	                                     : {1'b0, {(VALUE_BITS-1){1'b1}}};

	// capture the scan outcome, then form the new value
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && tok_f[ENTRIES].live) begin
			end_hit_q  <= tok_f[ENTRIES].hit;
			end_free_q <= tok_f[ENTRIES].free_found;
			end_val_q  <= tok_v[ENTRIES];
		end
		if (state_q == ST_CALC) begin
			if (cmd_q == CMD_ACC) begin
				newv_q  <= sum_ovf ? sat_val : sum_ext[VALUE_BITS-1:0];
				clamp_q <= sum_ovf;
			end else begin
				newv_q  <= val_q;
				clamp_q <= 1'b0;
			end
		end
	end

	// decide the write-back
	assign is_write  = (cmd_q == CMD_SET) || (cmd_q == CMD_ACC);
	assign newv_zero = (newv_q == '0);
	assign do_drop   = is_write && !newv_zero && !end_hit_q && !end_free_q;

	always_comb begin
		ctl = '0;
		if (state_q == ST_COMMIT && is_write) begin
			ctl.del_hit  = newv_zero && end_hit_q;
			ctl.upd_hit  = !newv_zero && end_hit_q;
			ctl.ins_free = !newv_zero && !end_hit_q && end_free_q;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.del_hit) begin
			count_q <= count_q - CW'(1);
		end else if (ctl.ins_free) begin
			count_q <= count_q + CW'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_COMMIT);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			present_q <= end_hit_q;
			drop_q    <= do_drop;
			sat_q     <= clamp_q;
			if (!is_write) begin
				result_q <= end_hit_q ? end_val_q : '0;
			end else if (newv_zero || do_drop) begin
				result_q <= '0;
			end else begin
				result_q <= newv_q;
			end
		end
	end

	assign done            = done_q;
	assign result_value    = result_q;
	assign was_present     = present_q;
	assign nonzero_count   = 7'(count_q);
	assign table_full_drop = drop_q;
	assign saturated       = sat_q;

	// a result lasts one cycle
	`SMES_ASSERT_NEXT(a_done_single, done, !done)
	// a clamped sum only comes from a stored cell
	`SMES_ASSERT_NOW(a_sat_present, done && saturated, was_present)
	// a dropped item never names a stored cell
	`SMES_ASSERT_NOW(a_drop_absent, done && table_full_drop, !was_present)
	// the count never runs past the table size
	`SMES_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(ENTRIES))

endmodule

// File: bench/sparse_matrix_entry_store_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sparse matrix entry store: directed rows, then random requests.
module sparse_matrix_entry_store_test
	import smes_pkg::*;
();

	localparam int          SLOTS      = 64;
	localparam int          POOL_ROWS  = 6;
	localparam int          POOL_COLS  = 12;
	localparam int          POOL_CELLS = POOL_ROWS * POOL_COLS;
	localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN      = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] value;
		logic        present;
		logic [6:0]  count;
		logic        drop;
		logic        sat;
	} cell_result_t;

	typedef struct {
		cmd_t         op;
		logic [15:0]  row;
		logic [15:0]  col;
		logic [31:0]  val;
		bit           typed;
		cell_result_t want;
	} request_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  cmd = CMD_GET;
	logic [15:0] row_index = '0;
	logic [15:0] col_index = '0;
	logic [31:0] cell_value = '0;
	logic        busy;
	logic        done;
	logic [31:0] result_value;
	logic        was_present;
	logic [6:0]  nonzero_count;
	logic        table_full_drop;
	logic        saturated;

	// Own copy of the stored cells
	logic        cell_live [SLOTS];
	logic [15:0] cell_row  [SLOTS];
	logic [15:0] cell_col  [SLOTS];
	logic [31:0] cell_val  [SLOTS];
	int          live_cells;

	logic [15:0]  pool_row [POOL_CELLS];
	logic [15:0]  pool_col [POOL_CELLS];
	request_row_t directed_rows [$];
	cell_result_t pending_results [$];
	int           mismatches = 0;

	sparse_matrix_entry_store #(
		.ENTRIES   (SLOTS),
		.INDEX_BITS(16),
		.VALUE_BITS(32)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.row_index      (row_index),
		.col_index      (col_index),
		.cell_value     (cell_value),
		.done           (done),
		.result_value   (result_value),
		.was_present    (was_present),
		.nonzero_count  (nonzero_count),
		.table_full_drop(table_full_drop),
		.saturated      (saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Slot holding a cell, or -1 when the cell is absent
	function automatic int find_cell(logic [15:0] r, logic [15:0] c);
		for (int i = 0; i < SLOTS; i++)
			if (cell_live[i] && cell_row[i] == r && cell_col[i] == c)
				return i;
		return -1;
	endfunction

	// Apply one request to the stored cells and return the result it gives
	function automatic cell_result_t apply_request(cmd_t op, logic [15:0] r, logic [15:0] c,
			logic [31:0] v);
		int           hit;
		int           free_slot;
		logic [31:0]  old_val;
		logic [32:0]  sum;
		logic [31:0]  next_val;
		cell_result_t res;
		hit = find_cell(r, c);
		free_slot = -1;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (!cell_live[i])
				free_slot = i;
		res = '0;
		res.present = (hit >= 0);
		old_val = (hit >= 0) ? cell_val[hit] : '0;
		if (op == CMD_SET || op == CMD_ACC) begin
			if (op == CMD_SET) begin
				next_val = v;
			end else begin
				// clamp when the sign-extended sum leaves the 32-bit range
				sum = {old_val[31], old_val} + {v[31], v};
				if (sum[32] != sum[31]) begin
					res.sat = 1'b1;
					next_val = sum[32] ? Q_MIN : Q_MAX;
				end else begin
					next_val = sum[31:0];
				end
			end
			if (next_val == '0) begin
				if (hit >= 0) begin
					cell_live[hit] = 1'b0;
					live_cells--;
				end
			end else if (hit >= 0) begin
				cell_val[hit] = next_val;
				res.value = next_val;
			end else if (free_slot >= 0) begin
				cell_live[free_slot] = 1'b1;
				cell_row[free_slot] = r;
				cell_col[free_slot] = c;
				cell_val[free_slot] = next_val;
				live_cells++;
				res.value = next_val;
			end else begin
				res.drop = 1'b1;
			end
		end else begin
			res.value = old_val;
		end
		res.count = 7'(live_cells);
		return res;
	endfunction

	function automatic void add_row(cmd_t op, logic [15:0] r, logic [15:0] c, logic [31:0] v,
			bit typed, logic [31:0] value, logic present, logic [6:0] count, logic drop,
			logic sat);
		request_row_t rq;
		rq.op = op;
		rq.row = r;
		rq.col = c;
		rq.val = v;
		rq.typed = typed;
		rq.want = '{value, present, count, drop, sat};
		directed_rows.push_back(rq);
	endfunction

	// Value for a random request: zeros, extremes, cancelling sums, small and wide values
	function automatic logic [31:0] pick_value(logic [15:0] r, logic [15:0] c, cmd_t op,
			int zero_pct);
		int          hit;
		int          pick;
		logic [20:0] fine;
		hit = find_cell(r, c);
		if ($urandom_range(99) < zero_pct)
			return '0;
		pick = $urandom_range(99);
		if (pick < 10) begin
			case ($urandom_range(3))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return 32'h0000_0001;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (pick < 30 && op == CMD_ACC && hit >= 0)
			return -cell_val[hit];
		if (pick < 65) begin
			fine = 21'($urandom);
			return {{11{fine[20]}}, fine};
		end
		return $urandom;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
		mismatches++;
	endtask

	// Offer one item and hold it until taken; log the expected result
	task automatic send_request(cmd_t op, logic [15:0] r, logic [15:0] c, logic [31:0] v,
			bit typed, cell_result_t want);
		cell_result_t predicted;
		start <= 1'b1;
		cmd <= op;
		row_index <= r;
		col_index <= c;
		cell_value <= v;
		do @(posedge clk); while (busy);
		predicted = apply_request(op, r, c, v);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic idle_sender(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 90)) @(posedge clk);
		end
	endtask

	// Hold off until every expected result has come back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Random requests, mostly on a pool of cells sharing rows and columns, larger than the table
	task automatic random_phase(int count, int idle_pct);
		cmd_t        op;
		logic [15:0] r;
		logic [15:0] c;
		logic [31:0] v;
		int          pick;
		int          zero_pct;
		zero_pct = 6;
		for (int n = 0; n < count; n++) begin
			// every hundred requests, choose at random between filling the table and emptying it
			if (n % 100 == 0)
				zero_pct = ($urandom_range(1) != 0) ? 40 : 6;
			pick = $urandom_range(99);
			op = (pick < 25) ? CMD_GET : (pick < 60) ? CMD_SET : (pick < 95) ? CMD_ACC : CMD_RSVD;
			if ($urandom_range(9) == 0) begin
				r = 16'($urandom);
				c = 16'($urandom);
			end else begin
				pick = $urandom_range(POOL_CELLS - 1);
				r = pool_row[pick];
				c = pool_col[pick];
			end
			v = pick_value(r, c, op, zero_pct);
			idle_sender(idle_pct);
			send_request(op, r, c, v, 1'b0, '0);
		end
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin : check_results
		cell_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, value", result_value, '0);
			end else begin
				want = pending_results.pop_front();
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (was_present !== want.present)
					report_mismatch("was_present", 32'(was_present), 32'(want.present));
				if (nonzero_count !== want.count)
					report_mismatch("nonzero_count", 32'(nonzero_count), 32'(want.count));
				if (table_full_drop !== want.drop)
					report_mismatch("table_full_drop", 32'(table_full_drop), 32'(want.drop));
				if (saturated !== want.sat)
					report_mismatch("saturated", 32'(saturated), 32'(want.sat));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("** sparse_matrix_entry_store: FAILED **");
		$finish;
	end

	initial begin
		logic [15:0] row_set [POOL_ROWS];
		logic [15:0] col_set [POOL_COLS];
		for (int i = 0; i < SLOTS; i++) begin
			cell_live[i] = 1'b0;
			cell_row[i] = '0;
			cell_col[i] = '0;
			cell_val[i] = '0;
		end
		live_cells = 0;
		foreach (row_set[i])
			row_set[i] = 16'($urandom);
		foreach (col_set[i])
			col_set[i] = 16'($urandom);
		for (int i = 0; i < POOL_CELLS; i++) begin
			pool_row[i] = row_set[i % POOL_ROWS];
			pool_col[i] = col_set[i / POOL_ROWS];
		end

		// empty table, unused command, zero to absent cells
		add_row(CMD_GET,  16'h0000, 16'h0000, 32'h0000_0000, 1, 32'h0, 0, 0, 0, 0);
		add_row(CMD_RSVD, 16'hFFFF, 16'hFFFF, Q_MAX,         1, 32'h0, 0, 0, 0, 0);
		add_row(CMD_SET,  16'h0000, 16'h0000, 32'h0000_0000, 1, 32'h0, 0, 0, 0, 0);
		add_row(CMD_ACC,  16'hFFFF, 16'hFFFF, 32'h0000_0000, 1, 32'h0, 0, 0, 0, 0);
		// extremes and saturation both ways
		add_row(CMD_SET,  16'hFFFF, 16'hFFFF, Q_MAX,         1, Q_MAX, 0, 1, 0, 0);
		add_row(CMD_ACC,  16'hFFFF, 16'hFFFF, 32'h0000_0001, 1, Q_MAX, 1, 1, 0, 1);
		add_row(CMD_SET,  16'h0000, 16'h0000, Q_MIN,         1, Q_MIN, 0, 2, 0, 0);
		add_row(CMD_ACC,  16'h0000, 16'h0000, 32'hFFFF_FFFF, 1, Q_MIN, 1, 2, 0, 1);
		add_row(CMD_ACC,  16'h0000, 16'h0000, Q_MIN,         1, Q_MIN, 1, 2, 0, 1);
		add_row(CMD_GET,  16'h0000, 16'h0000, 32'hFFFF_FFFF, 1, Q_MIN, 1, 2, 0, 0);
		// delete by zero set, then read back
		add_row(CMD_SET,  16'hFFFF, 16'hFFFF, 32'h0000_0000, 1, 32'h0, 1, 1, 0, 0);
		add_row(CMD_GET,  16'hFFFF, 16'hFFFF, 32'h0000_0000, 1, 32'h0, 0, 1, 0, 0);
		// sum to minus one, then cancel to zero
		add_row(CMD_ACC,  16'h0000, 16'h0000, Q_MAX,         0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_ACC,  16'h0000, 16'h0000, 32'h0000_0001, 1, 32'h0, 1, 0, 0, 0);
		// insert by accumulate, update, transposed and partial matches
		add_row(CMD_ACC,  16'h1234, 16'h5678, 32'h0001_0000, 0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_SET,  16'h1234, 16'h5678, 32'h0002_0000, 0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_RSVD, 16'h1234, 16'h5678, 32'h0000_0000, 0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_GET,  16'h5678, 16'h1234, 32'h0000_0000, 0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_SET,  16'h1234, 16'hFFFF, 32'h5555_AAAA, 0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_ACC,  16'h1234, 16'h5678, 32'hFFFE_0000, 0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_SET,  16'hFFFF, 16'h0000, 32'hAAAA_5555, 0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_SET,  16'h0000, 16'hFFFF, 32'h0000_0001, 0, 32'h0, 0, 0, 0, 0);
		add_row(CMD_GET,  16'h1234, 16'hFFFF, 32'h0000_0000, 0, 32'h0, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].row, directed_rows[i].col,
				directed_rows[i].val, directed_rows[i].typed, directed_rows[i].want);
		wait_drained();

		random_phase(500, 32);
		wait_drained();
		random_phase(500, 80);
		wait_drained();
		random_phase(450, 0);

		// drain, then watch for stray results
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("** sparse_matrix_entry_store: PASSED **");
		else
			$display("** sparse_matrix_entry_store: FAILED **");
		$finish;
	end

endmodule
